@@ src/fdt_pkg.sv @@
package fdt_pkg;

  localparam int ENTRIES    = 16;
  localparam int IDX_W      = $clog2(ENTRIES);
  localparam int CNT_W      = $clog2(ENTRIES + 1);
  localparam int PAGE_BYTES = 256;
  localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
  localparam int DATA_BYTES = 31488;
  localparam int SIZE_W     = 15;
  localparam int REQ_SIZE_W = 16;
  localparam int NEED_W     = REQ_SIZE_W + 1;

  localparam logic [2:0] REQ_FIND    = 3'd0;
  localparam logic [2:0] REQ_ALLOC   = 3'd1;
  localparam logic [2:0] REQ_DELETE  = 3'd2;
  localparam logic [2:0] REQ_STATE   = 3'd3;
  localparam logic [2:0] REQ_SUMMARY = 3'd4;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NO_PAK    = 3'd1;
  localparam logic [2:0] ST_INVALID   = 3'd2;
  localparam logic [2:0] ST_DATA_FULL = 3'd3;
  localparam logic [2:0] ST_DIR_FULL  = 3'd4;
  localparam logic [2:0] ST_EXISTS    = 3'd5;

  typedef struct packed {
    logic [15:0]       company;
    logic [31:0]       game;
    logic [63:0]       name_hi;
    logic [63:0]       name_lo;
    logic [31:0]       ext;
    logic [SIZE_W-1:0] bytes;
  } entry_t;

  typedef struct packed {
    logic             re;
    logic             we;
    logic [IDX_W-1:0] addr;
    entry_t           wdata;
  } ram_req_t;

  typedef struct packed {
    logic [2:0]            req_type;
    logic [15:0]           company;
    logic [31:0]           game;
    logic [63:0]           name_hi;
    logic [63:0]           name_lo;
    logic [31:0]           ext;
    logic [REQ_SIZE_W-1:0] size;
    logic [3:0]            fidx;
  } req_item_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [3:0]        entry_index;
    logic [SIZE_W-1:0] entry_size;
    logic [15:0]       found_company;
    logic [31:0]       found_game;
    logic [31:0]       found_extension;
    logic [63:0]       found_name_hi;
    logic [63:0]       found_name_lo;
    logic [SIZE_W-1:0] free_bytes;
    logic [4:0]        file_count;
  } result_t;

  function automatic logic [NEED_W-1:0] page_round(input logic [REQ_SIZE_W-1:0] v);
    logic [NEED_W-1:0] sum;
    sum = {1'b0, v} + NEED_W'(PAGE_BYTES - 1);
    return (sum >> PAGE_SHIFT) << PAGE_SHIFT;
  endfunction

endpackage

@@ src/file_directory_table_unit.sv @@
// Find, allocate and delete scan all entries before their result is registered;
// entry state reads one entry; summary, disabled, unknown and zero-size allocate read none.
// One request at a time; a new beat is taken the cycle after the result is registered.
// Scan time is set by the entry memory's single port: one entry read per cycle.
// Synchronous active-low reset empties the directory and sets pak_enabled to 1.
module file_directory_table_unit
  import fdt_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic         cfg_data,      // pak_enabled
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [2:0]   in_tuser,      // req_type
  // company, game, name_hi, name_lo, extension, requested_size, file_index
  input  logic [231:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // status, entry_index, entry_size, found_company, found_game, found_extension,
  // found_name_hi, found_name_lo, free_bytes, file_count
  output logic [255:0] out_tdata
);

  logic      pak_en_r;
  req_item_t in_req;
  result_t   res;
  ram_req_t  ram_req;
  entry_t    ram_rdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pak_en_r <= 1'b1;
    end else if (cfg_valid) begin
      pak_en_r <= cfg_data;
    end
  end

  assign in_req.req_type = in_tuser;
  assign in_req.company  = in_tdata[15:0];
  assign in_req.game     = in_tdata[47:16];
  assign in_req.name_hi  = in_tdata[111:48];
  assign in_req.name_lo  = in_tdata[175:112];
  assign in_req.ext      = in_tdata[207:176];
  assign in_req.size     = in_tdata[223:208];
  assign in_req.fidx     = in_tdata[227:224];

  assign out_tdata = {6'd0, res.file_count, res.free_bytes, res.found_name_lo,
                      res.found_name_hi, res.found_extension, res.found_game,
                      res.found_company, res.entry_size, res.entry_index, res.status};

  fdt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .pak_en    (pak_en_r),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_req    (in_req),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (res),
    .ram_req   (ram_req),
    .ram_rdata (ram_rdata)
  );

  fdt_entry_ram u_ram (
    .clk     (clk),
    .ram_req (ram_req),
    .rdata   (ram_rdata)
  );

endmodule

@@ src/fdt_entry_ram.sv @@
module fdt_entry_ram
  import fdt_pkg::*;
(
  input  logic     clk,
  input  ram_req_t ram_req,
  output entry_t   rdata
);

  entry_t mem_r [ENTRIES];
  entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (ram_req.we) begin
      mem_r[ram_req.addr] <= ram_req.wdata;
    end
    if (ram_req.re) begin
      rdata_r <= mem_r[ram_req.addr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ src/fdt_ctrl.sv @@
module fdt_ctrl
  import fdt_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      pak_en,
  input  logic      in_valid,
  output logic      in_ready,
  input  req_item_t in_req,
  output logic      out_valid,
  input  logic      out_ready,
  output result_t   out_res,
  output ram_req_t  ram_req,
  input  entry_t    ram_rdata
);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_STATE_RD, S_DONE} state_t;

  state_t            state_r;
  req_item_t         req_r;
  logic              en_r;
  logic [CNT_W-1:0]  scan_cnt_r;
  logic              cmp_vld_r;
  logic [IDX_W-1:0]  cmp_idx_r;
  logic              hit_r;
  logic [IDX_W-1:0]  hit_idx_r;
  logic [SIZE_W-1:0] hit_bytes_r;
  logic [ENTRIES-1:0] valid_r;
  logic [SIZE_W-1:0] used_r;
  logic [CNT_W-1:0]  count_r;
  result_t           out_r;
  logic              out_valid_r;

  logic              key_eq;
  logic              cmp_hit;
  logic              free_any;
  logic [IDX_W-1:0]  free_idx;
  logic [NEED_W-1:0] need;
  logic [NEED_W-1:0] del_round;
  logic [SIZE_W-1:0] room;
  logic              out_slot;
  logic              do_alloc;
  logic              do_delete;
  result_t           res_nxt;

  assign key_eq = ram_rdata.company == req_r.company && ram_rdata.game == req_r.game &&
                  ram_rdata.name_hi == req_r.name_hi && ram_rdata.name_lo == req_r.name_lo &&
                  ram_rdata.ext == req_r.ext;
  assign cmp_hit   = cmp_vld_r && valid_r[cmp_idx_r] && key_eq && !hit_r;
  assign free_any  = ~&valid_r;
  assign need      = page_round(req_r.size);
  assign del_round = page_round({1'b0, hit_bytes_r});
  assign room      = SIZE_W'(DATA_BYTES) - used_r;
  assign out_slot  = !out_valid_r || out_ready;

  always_comb begin
    free_idx = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        free_idx = IDX_W'(i);
      end
    end
  end

  always_comb begin
    res_nxt   = '0;
    do_alloc  = 1'b0;
    do_delete = 1'b0;
    if (!en_r) begin
      res_nxt.status = ST_NO_PAK;
    end else begin
      case (req_r.req_type)
        REQ_FIND: begin
          if (hit_r) begin
            res_nxt.status      = ST_OK;
            res_nxt.entry_index = 4'(hit_idx_r);
          end else begin
            res_nxt.status = ST_INVALID;
          end
        end
        REQ_ALLOC: begin
          if (req_r.size == '0) begin
            res_nxt.status = ST_INVALID;
          end else if (hit_r) begin
            res_nxt.status = ST_EXISTS;
          end else if (!free_any) begin
            res_nxt.status = ST_DIR_FULL;
          end else if (need > NEED_W'(room)) begin
            res_nxt.status = ST_DATA_FULL;
          end else begin
            res_nxt.status      = ST_OK;
            res_nxt.entry_index = 4'(free_idx);
            do_alloc            = 1'b1;
          end
        end
        REQ_DELETE: begin
          if (hit_r) begin
            res_nxt.status = ST_OK;
            do_delete      = 1'b1;
          end else begin
            res_nxt.status = ST_INVALID;
          end
        end
        REQ_STATE: begin
          if (valid_r[req_r.fidx[IDX_W-1:0]]) begin
            res_nxt.status          = ST_OK;
            res_nxt.entry_size      = ram_rdata.bytes;
            res_nxt.found_company   = ram_rdata.company;
            res_nxt.found_game      = ram_rdata.game;
            res_nxt.found_extension = ram_rdata.ext;
            res_nxt.found_name_hi   = ram_rdata.name_hi;
            res_nxt.found_name_lo   = ram_rdata.name_lo;
          end else begin
            res_nxt.status = ST_INVALID;
          end
        end
        REQ_SUMMARY: begin
          res_nxt.status     = ST_OK;
          res_nxt.free_bytes = room;
          res_nxt.file_count = 5'(count_r);
        end
        default: begin
          res_nxt.status = ST_INVALID;
        end
      endcase
    end
  end

  always_comb begin
    ram_req = '0;
    if (state_r == S_SCAN && scan_cnt_r < CNT_W'(ENTRIES)) begin
      ram_req.re   = 1'b1;
      ram_req.addr = scan_cnt_r[IDX_W-1:0];
    end else if (state_r == S_STATE_RD) begin
      ram_req.re   = 1'b1;
      ram_req.addr = req_r.fidx[IDX_W-1:0];
    end else if (state_r == S_DONE && out_slot && do_alloc) begin
      ram_req.we            = 1'b1;
      ram_req.addr          = free_idx;
      ram_req.wdata.company = req_r.company;
      ram_req.wdata.game    = req_r.game;
      ram_req.wdata.name_hi = req_r.name_hi;
      ram_req.wdata.name_lo = req_r.name_lo;
      ram_req.wdata.ext     = req_r.ext;
      ram_req.wdata.bytes   = req_r.size[SIZE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      valid_r     <= '0;
      used_r      <= '0;
      count_r     <= '0;
      hit_r       <= 1'b0;
      cmp_vld_r   <= 1'b0;
    end else begin
      if (out_valid_r && out_ready && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end
      cmp_vld_r <= ram_req.re && state_r == S_SCAN;
      cmp_idx_r <= ram_req.addr;
      if (cmp_hit) begin
        hit_r       <= 1'b1;
        hit_idx_r   <= cmp_idx_r;
        hit_bytes_r <= ram_rdata.bytes;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            req_r      <= in_req;
            en_r       <= pak_en;
            hit_r      <= 1'b0;
            scan_cnt_r <= '0;
            if (!pak_en) begin
              state_r <= S_DONE;
            end else begin
              case (in_req.req_type) inside
                REQ_FIND, REQ_DELETE: state_r <= S_SCAN;
                REQ_ALLOC:            state_r <= (in_req.size == '0) ? S_DONE : S_SCAN;
                REQ_STATE:            state_r <= S_STATE_RD;
                default:              state_r <= S_DONE;
              endcase
            end
          end
        end
        S_SCAN: begin
          scan_cnt_r <= scan_cnt_r + 1'b1;
          if (scan_cnt_r == CNT_W'(ENTRIES)) begin
            state_r <= S_DONE;
          end
        end
        S_STATE_RD: begin
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (out_slot) begin
            out_r       <= res_nxt;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
            if (do_alloc) begin
              valid_r[free_idx] <= 1'b1;
              used_r            <= used_r + need[SIZE_W-1:0];
              count_r           <= count_r + 1'b1;
            end
            if (do_delete) begin
              valid_r[hit_idx_r] <= 1'b0;
              used_r             <= used_r - del_round[SIZE_W-1:0];
              count_r            <= count_r - 1'b1;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ready  = state_r == S_IDLE;
  assign out_valid = out_valid_r;
  assign out_res   = out_r;

endmodule
